// ----- sv/dvbb_pkg.sv -----
`timescale 1ns / 1ps

package dvbb_pkg;

   localparam int unsigned FUEL_HOLD_TICKS_DEF     = 10;
   localparam int unsigned OXIDIZER_HOLD_TICKS_DEF = 10;
   localparam int unsigned REDLINE_LIMIT_TICKS_DEF = 100;
   localparam int unsigned PRESSURE_BITS_DEF       = 16;

   localparam int unsigned HOLD_BITS    = 8;
   localparam int unsigned REDLINE_BITS = 16;
   localparam int unsigned MODE_BITS    = 2;
   localparam int unsigned CHANNELS     = 2;
   localparam int unsigned RSP_BITS     = 8;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ISOLATE  = 2'd0,
      MODE_OPEN     = 2'd1,
      MODE_REGULATE = 2'd2
   } mode_type;

   localparam logic [MODE_BITS-1:0] MODE_CODE_INVALID = 2'd3;

   typedef enum logic [2:0] {
      REG_FUEL_UPPER     = 3'd0,
      REG_FUEL_LOWER     = 3'd1,
      REG_OXIDIZER_UPPER = 3'd2,
      REG_OXIDIZER_LOWER = 3'd3,
      REG_FUEL_REDLINE   = 3'd4,
      REG_OXIDIZER_REDLINE = 3'd5
   } reg_idx_type;

endpackage

// ----- sv/dual_valve_bang_bang_regulator_core.sv -----
`timescale 1ns / 1ps

// channel | direction | handshake               | payload
// req     | in        | req_tvalid / req_tready | pressures and mode commands
// rsp     | out       | rsp_tvalid / rsp_tready | valve drives, modes, hit flags
// csr     | in        | apb write, always ready | setpoints and redlines
//
// one item per clock sustained while rsp_tready stays high; an item leaves through
// the input register, then the result register (all tick logic sits between them)
// reset returns both channels to isolate with valves closed and counters cleared
// a stalled result holds in the result register; the input register keeps
// taking items until both stages are full

module dual_valve_bang_bang_regulator_core #(
   parameter int unsigned FUEL_HOLD_TICKS     = dvbb_pkg::FUEL_HOLD_TICKS_DEF,
   parameter int unsigned OXIDIZER_HOLD_TICKS = dvbb_pkg::OXIDIZER_HOLD_TICKS_DEF,
   parameter int unsigned REDLINE_LIMIT_TICKS = dvbb_pkg::REDLINE_LIMIT_TICKS_DEF,
   parameter int unsigned PRESSURE_BITS       = dvbb_pkg::PRESSURE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // fuel_pressure, oxidizer_pressure, fuel_mode_write, fuel_mode_new,
   // oxidizer_mode_write, oxidizer_mode_new, zero fill
   input  logic [((2*PRESSURE_BITS+6+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fuel_valve_open, oxidizer_valve_open, fuel_mode_now, oxidizer_mode_now,
   // fuel_redline_hit, oxidizer_redline_hit
   output logic [dvbb_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [$clog2(6*(((PRESSURE_BITS+1) > 32) ? 8 : 4))-1:0] paddr,
   input  logic [(((PRESSURE_BITS+1) > 32) ? 64 : 32)-1:0] pwdata,
   output logic [(((PRESSURE_BITS+1) > 32) ? 64 : 32)-1:0] prdata,
   output logic pready
);

   import dvbb_pkg::*;

   localparam int unsigned CsrDataBits = ((PRESSURE_BITS + 1) > 32) ? 64 : 32;
   localparam int unsigned StrideBits  = (CsrDataBits == 64) ? 3 : 2;
   localparam int unsigned AddrBits    = $clog2(6 * (CsrDataBits / 8));
   localparam int unsigned P           = PRESSURE_BITS;
   localparam logic [HOLD_BITS-1:0] HoldMax = '1;
   localparam logic [REDLINE_BITS-1:0] CountMax = '1;
   localparam logic [REDLINE_BITS-1:0] LimitTicks = REDLINE_BITS'(REDLINE_LIMIT_TICKS);
   localparam logic [HOLD_BITS-1:0] HoldMin [CHANNELS] = '{
      HOLD_BITS'(FUEL_HOLD_TICKS), HOLD_BITS'(OXIDIZER_HOLD_TICKS)
   };

   // configuration
   logic [P:0]   upper_ff [CHANNELS];
   logic [P-1:0] lower_ff [CHANNELS];
   logic [P:0]   redline_ff [CHANNELS];
   logic         csr_write;
   reg_idx_type  csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = reg_idx_type'(paddr[AddrBits-1:StrideBits]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            upper_ff[c]   <= {1'b1, {P{1'b0}}};
            lower_ff[c]   <= '0;
            redline_ff[c] <= {1'b1, {P{1'b0}}};
         end
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_FUEL_UPPER:       upper_ff[0]   <= pwdata[P:0];
            REG_FUEL_LOWER:       lower_ff[0]   <= pwdata[P-1:0];
            REG_OXIDIZER_UPPER:   upper_ff[1]   <= pwdata[P:0];
            REG_OXIDIZER_LOWER:   lower_ff[1]   <= pwdata[P-1:0];
            REG_FUEL_REDLINE:     redline_ff[0] <= pwdata[P:0];
            REG_OXIDIZER_REDLINE: redline_ff[1] <= pwdata[P:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FUEL_UPPER:       prdata = CsrDataBits'(upper_ff[0]);
         REG_FUEL_LOWER:       prdata = CsrDataBits'(lower_ff[0]);
         REG_OXIDIZER_UPPER:   prdata = CsrDataBits'(upper_ff[1]);
         REG_OXIDIZER_LOWER:   prdata = CsrDataBits'(lower_ff[1]);
         REG_FUEL_REDLINE:     prdata = CsrDataBits'(redline_ff[0]);
         REG_OXIDIZER_REDLINE: prdata = CsrDataBits'(redline_ff[1]);
         default:              prdata = '0;
      endcase
   end

   // input register
   logic                 in_valid_ff;
   logic [P-1:0]         in_pressure_ff [CHANNELS];
   logic                 in_write_ff [CHANNELS];
   logic [MODE_BITS-1:0] in_mode_ff [CHANNELS];
   logic                 out_free;
   logic                 advance;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pressure_ff[0] <= req_tdata[P-1:0];
         in_pressure_ff[1] <= req_tdata[2*P-1:P];
         in_write_ff[0]    <= req_tdata[2*P];
         in_mode_ff[0]     <= req_tdata[2*P+2:2*P+1];
         in_write_ff[1]    <= req_tdata[2*P+3];
         in_mode_ff[1]     <= req_tdata[2*P+5:2*P+4];
      end
   end

   // tick state
   mode_type                mode_ff [CHANNELS];
   logic                    intended_ff [CHANNELS];
   logic                    valve_ff [CHANNELS];
   logic [HOLD_BITS-1:0]    hold_ff [CHANNELS];
   logic                    hit_ff [CHANNELS];
   logic [REDLINE_BITS-1:0] over_count_ff;

   mode_type                mode_in [CHANNELS];
   logic                    intended_in [CHANNELS];
   logic                    valve_in [CHANNELS];
   logic [HOLD_BITS-1:0]    hold_in [CHANNELS];
   logic                    hit_in [CHANNELS];
   logic [REDLINE_BITS-1:0] over_count_in;
   logic                    over [CHANNELS];
   logic                    moved [CHANNELS];
   logic                    any_over;
   logic                    abort;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (in_write_ff[c] && in_mode_ff[c] != MODE_CODE_INVALID) begin
            mode_in[c] = mode_type'(in_mode_ff[c]);
         end else begin
            mode_in[c] = mode_ff[c];
         end
         unique case (mode_in[c])
            MODE_ISOLATE: intended_in[c] = 1'b0;
            MODE_OPEN:    intended_in[c] = 1'b1;
            MODE_REGULATE: begin
               priority if ({1'b0, in_pressure_ff[c]} >= upper_ff[c]) begin
                  intended_in[c] = 1'b0;
               end else if (in_pressure_ff[c] <= lower_ff[c]) begin
                  intended_in[c] = 1'b1;
               end else begin
                  intended_in[c] = intended_ff[c];
               end
            end
            default: intended_in[c] = 1'b0;
         endcase
         moved[c] = (hold_ff[c] >= HoldMin[c]) && (valve_ff[c] != intended_in[c]);
         valve_in[c] = moved[c] ? intended_in[c] : valve_ff[c];
         if (moved[c]) begin
            hold_in[c] = HOLD_BITS'(1);
         end else if (hold_ff[c] != HoldMax) begin
            hold_in[c] = hold_ff[c] + HOLD_BITS'(1);
         end else begin
            hold_in[c] = hold_ff[c];
         end
         over[c]   = {1'b0, in_pressure_ff[c]} >= redline_ff[c];
         hit_in[c] = hit_ff[c];
      end

      any_over = over[0] || over[1];
      if (!any_over) begin
         over_count_in = '0;
      end else if (over_count_ff != CountMax) begin
         over_count_in = over_count_ff + REDLINE_BITS'(1);
      end else begin
         over_count_in = over_count_ff;
      end
      abort = any_over && (over_count_in > LimitTicks);

      if (abort) begin
         for (int c = 0; c < CHANNELS; c++) begin
            valve_in[c] = 1'b0;
            mode_in[c]  = MODE_ISOLATE;
            hit_in[c]   = over[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            mode_ff[c]     <= MODE_ISOLATE;
            intended_ff[c] <= 1'b0;
            valve_ff[c]    <= 1'b0;
            hold_ff[c]     <= '0;
            hit_ff[c]      <= 1'b0;
         end
         over_count_ff <= '0;
      end else if (advance) begin
         for (int c = 0; c < CHANNELS; c++) begin
            mode_ff[c]     <= mode_in[c];
            intended_ff[c] <= intended_in[c];
            valve_ff[c]    <= valve_in[c];
            hold_ff[c]     <= hold_in[c];
            hit_ff[c]      <= hit_in[c];
         end
         over_count_ff <= over_count_in;
      end
   end

   // result register
   logic rsp_valid_ff;
   logic [RSP_BITS-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {hit_in[1], hit_in[0], mode_in[1], mode_in[0],
                         valve_in[1], valve_in[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import dvbb_pkg::*;

   localparam int unsigned P_BITS   = PRESSURE_BITS_DEF;
   localparam int unsigned REQ_BITS = ((2*P_BITS+6+7)/8)*8;

   typedef struct {
      mode_type          mode;
      logic              intended;
      logic              valve;
      logic              hit;
      logic [HOLD_BITS-1:0] hold;
      logic [P_BITS:0]   upper;
      logic [P_BITS-1:0] lower;
      logic [P_BITS:0]   redline;
   } channel_state_type;

   typedef struct {
      logic       fuel_valve;
      logic       oxid_valve;
      logic [1:0] fuel_mode;
      logic [1:0] oxid_mode;
      logic       fuel_hit;
      logic       oxid_hit;
   } valve_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   dual_valve_bang_bang_regulator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   channel_state_type fuel_ch;
   channel_state_type oxid_ch;
   logic [REDLINE_BITS-1:0] over_redline_ticks;

   logic [REQ_BITS-1:0] pending_ticks[$];
   valve_result_type    expected_outputs[$];
   int unsigned ticks_queued = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;

   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit rsp_hold_pending = 1'b0;
   int rsp_hold_left = 0;
   int fuel_over_left = 0;
   int oxid_over_left = 0;

   function automatic channel_state_type tick_channel(channel_state_type c,
                                                      logic [P_BITS-1:0] p,
                                                      logic wr, logic [1:0] new_mode,
                                                      int unsigned hold_min);
      channel_state_type n;
      n = c;
      if (wr && new_mode != MODE_CODE_INVALID) n.mode = mode_type'(new_mode);
      case (n.mode)
         MODE_ISOLATE: n.intended = 1'b0;
         MODE_OPEN:    n.intended = 1'b1;
         default: begin
            if ({1'b0, p} >= n.upper) n.intended = 1'b0;
            else if (p <= n.lower) n.intended = 1'b1;
         end
      endcase
      if (n.hold >= hold_min && n.valve != n.intended) begin
         n.valve = n.intended;
         n.hold = HOLD_BITS'(1);
      end else if (n.hold != '1) begin
         n.hold = n.hold + 1'b1;
      end
      return n;
   endfunction

   function automatic valve_result_type advance_regulator(logic [REQ_BITS-1:0] d);
      logic [P_BITS-1:0] fp;
      logic [P_BITS-1:0] op;
      logic f_over;
      logic o_over;
      valve_result_type r;
      fp = d[15:0];
      op = d[31:16];
      fuel_ch = tick_channel(fuel_ch, fp, d[32], d[34:33], FUEL_HOLD_TICKS_DEF);
      oxid_ch = tick_channel(oxid_ch, op, d[35], d[37:36], OXIDIZER_HOLD_TICKS_DEF);
      f_over = {1'b0, fp} >= fuel_ch.redline;
      o_over = {1'b0, op} >= oxid_ch.redline;
      if (f_over || o_over) begin
         if (over_redline_ticks != '1) over_redline_ticks = over_redline_ticks + 1'b1;
         if (over_redline_ticks > REDLINE_LIMIT_TICKS_DEF) begin
            fuel_ch.valve = 1'b0;
            oxid_ch.valve = 1'b0;
            fuel_ch.mode = MODE_ISOLATE;
            oxid_ch.mode = MODE_ISOLATE;
            fuel_ch.hit = f_over;
            oxid_ch.hit = o_over;
         end
      end else begin
         over_redline_ticks = '0;
      end
      r.fuel_valve = fuel_ch.valve;
      r.oxid_valve = oxid_ch.valve;
      r.fuel_mode  = fuel_ch.mode;
      r.oxid_mode  = oxid_ch.mode;
      r.fuel_hit   = fuel_ch.hit;
      r.oxid_hit   = oxid_ch.hit;
      return r;
   endfunction

   function automatic logic [P_BITS-1:0] draw_pressure(channel_state_type c, bit over_run);
      int v;
      int unsigned pick;
      if (over_run && c.redline <= 17'hFFFF) return P_BITS'($urandom_range(c.redline, 16'hFFFF));
      pick = $urandom_range(0, 9);
      case (pick)
         0:       v = $urandom_range(0, 1) ? 65535 : 0;
         1, 2:    v = $urandom_range(0, 65535);
         3, 4, 5: v = int'(c.lower) + int'($urandom_range(0, 128)) - 64;
         6, 7, 8: v = int'(c.upper) + int'($urandom_range(0, 128)) - 64;
         default: v = int'(c.redline) + int'($urandom_range(0, 128)) - 64;
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return P_BITS'(v);
   endfunction

   function automatic logic [1:0] draw_mode();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return MODE_REGULATE;
      if (r < 7) return MODE_OPEN;
      if (r < 9) return MODE_ISOLATE;
      return MODE_CODE_INVALID;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic queue_tick(logic [15:0] fp, logic [15:0] op, logic fw, logic [1:0] fm,
                             logic ow, logic [1:0] om);
      pending_ticks.push_back({2'b00, om, ow, fm, fw, op, fp});
      ticks_queued++;
   endtask

   task automatic queue_random_ticks(int count);
      bit f_run;
      bit o_run;
      repeat (count) begin
         if (fuel_over_left == 0 && $urandom_range(0, 119) == 0)
            fuel_over_left = $urandom_range(60, 160);
         if (oxid_over_left == 0 && $urandom_range(0, 119) == 0)
            oxid_over_left = $urandom_range(60, 160);
         f_run = fuel_over_left > 0;
         o_run = oxid_over_left > 0;
         if (f_run) fuel_over_left--;
         if (o_run) oxid_over_left--;
         queue_tick(draw_pressure(fuel_ch, f_run), draw_pressure(oxid_ch, o_run),
                    $urandom_range(0, 7) == 0, draw_mode(),
                    $urandom_range(0, 7) == 0, draw_mode());
      end
   endtask

   task automatic csr_write(reg_idx_type idx, int unsigned value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FUEL_UPPER:       fuel_ch.upper = value[16:0];
         REG_FUEL_LOWER:       fuel_ch.lower = value[15:0];
         REG_OXIDIZER_UPPER:   oxid_ch.upper = value[16:0];
         REG_OXIDIZER_LOWER:   oxid_ch.lower = value[15:0];
         REG_FUEL_REDLINE:     fuel_ch.redline = value[16:0];
         REG_OXIDIZER_REDLINE: oxid_ch.redline = value[16:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (results_seen != ticks_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // item sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fire)) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (pending_ticks.size() > 0) begin
            req_tdata <= pending_ticks.pop_front();
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 49) == 0) req_burst = !req_burst;
            req_gap = draw_wait(req_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_hold_pending) begin
         rsp_hold_pending = 1'b0;
         rsp_hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
            rsp_stall = draw_wait(rsp_burst);
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // handshake monitor and checker
   always @(posedge clock) begin
      valve_result_type want;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fire) begin
         results_seen++;
         if (expected_outputs.size() == 0) begin
            $error("result with no tick pending: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_outputs.pop_front();
            check_field("fuel_valve_open", want.fuel_valve, rsp_tdata[0]);
            check_field("oxidizer_valve_open", want.oxid_valve, rsp_tdata[1]);
            check_field("fuel_mode_now", want.fuel_mode, rsp_tdata[3:2]);
            check_field("oxidizer_mode_now", want.oxid_mode, rsp_tdata[5:4]);
            check_field("fuel_redline_hit", want.fuel_hit, rsp_tdata[6]);
            check_field("oxidizer_redline_hit", want.oxid_hit, rsp_tdata[7]);
         end
      end
      if (req_fire) expected_outputs.push_back(advance_regulator(req_tdata));
   end

   initial begin
      int unsigned lo;
      int unsigned up;
      int unsigned span;
      fuel_ch = '{MODE_ISOLATE, 1'b0, 1'b0, 1'b0, '0, 17'h10000, '0, 17'h10000};
      oxid_ch = fuel_ch;
      over_redline_ticks = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hold counted from reset, ignored mode code, never-closing upper setpoint
      queue_tick(16'h0000, 16'h0000, 1'b1, MODE_OPEN, 1'b1, MODE_REGULATE);
      repeat (10) queue_tick(16'h0000, 16'h0000, 1'b0, MODE_ISOLATE, 1'b0, MODE_ISOLATE);
      queue_tick(16'hFFFF, 16'hFFFF, 1'b1, MODE_CODE_INVALID, 1'b1, MODE_CODE_INVALID);
      queue_tick(16'hFFFF, 16'hFFFF, 1'b1, MODE_REGULATE, 1'b0, MODE_ISOLATE);
      queue_tick(16'h8000, 16'h0001, 1'b1, MODE_ISOLATE, 1'b1, MODE_OPEN);
      repeat (3) queue_tick(16'h5555, 16'hAAAA, 1'b0, MODE_ISOLATE, 1'b0, MODE_ISOLATE);
      wait_drained();

      // extreme limits: always at or above upper, fuel permanently over redline
      csr_write(REG_FUEL_UPPER, 0);
      csr_write(REG_FUEL_LOWER, 65535);
      csr_write(REG_OXIDIZER_UPPER, 0);
      csr_write(REG_OXIDIZER_LOWER, 65535);
      csr_write(REG_FUEL_REDLINE, 0);
      csr_write(REG_OXIDIZER_REDLINE, 65535);
      queue_tick(16'h0000, 16'hFFFF, 1'b1, MODE_REGULATE, 1'b1, MODE_REGULATE);
      queue_tick(16'hFFFF, 16'h0000, 1'b0, MODE_ISOLATE, 1'b0, MODE_ISOLATE);
      queue_tick(16'h0000, 16'hFFFE, 1'b1, MODE_OPEN, 1'b1, MODE_REGULATE);
      queue_tick(16'h1234, 16'hFFFF, 1'b0, MODE_ISOLATE, 1'b0, MODE_ISOLATE);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase != 0) begin
            wait_drained();
            if (phase == 7) begin
               csr_write(REG_FUEL_UPPER, 65536);
               csr_write(REG_FUEL_LOWER, 0);
               csr_write(REG_OXIDIZER_UPPER, 65536);
               csr_write(REG_OXIDIZER_LOWER, 0);
               csr_write(REG_FUEL_REDLINE, 65536);
               csr_write(REG_OXIDIZER_REDLINE, 65536);
            end else begin
               for (int ch = 0; ch < 2; ch++) begin
                  lo = $urandom_range(0, 65535);
                  span = $urandom_range(1, 4000);
                  if ($urandom_range(0, 4) == 0) up = $urandom_range(0, 65536);
                  else up = (lo + span > 65536) ? 65536 : lo + span;
                  csr_write(ch ? REG_OXIDIZER_UPPER : REG_FUEL_UPPER, up);
                  csr_write(ch ? REG_OXIDIZER_LOWER : REG_FUEL_LOWER, lo);
                  csr_write(ch ? REG_OXIDIZER_REDLINE : REG_FUEL_REDLINE,
                            ($urandom_range(0, 3) == 0) ? 65536 : $urandom_range(1024, 65535));
               end
            end
            if (phase == 3) rsp_hold_pending = 1'b1;
         end
         queue_random_ticks(200);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_outputs.size() != 0) begin
         $error("%0d results never arrived", expected_outputs.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
